>>> sv/ils_pkg.sv
// shared types and constants for the indexed list stack
// no dependencies; imported by the interfaces, the cell row, the top level and the checker
package ils_pkg;

    localparam int VALUE_W       = 32;
    localparam int POS_W         = 5;
    localparam int CNT_W         = 5;
    localparam int IDX_MAX_W     = 8;
    localparam int DEPTH_DEF     = 16;
    localparam int DATA_W_DEF    = 32;

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_DELETE  = 2'd1,
        CMD_REVERSE = 2'd2,
        CMD_PEEK    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_DEL
    } cell_op_t;

    // broadcast to every cell of the row
    typedef struct packed {
        cell_op_t               op;
        logic [IDX_MAX_W-1:0]   q;
        logic                   head_en;
        logic [IDX_MAX_W-1:0]   head_idx;
    } cell_ctrl_t;

endpackage

>>> sv/ils_if.sv
// command and response channel interfaces for the indexed list stack
// depends on ils_pkg
interface ils_cmd_if import ils_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [1:0]                 command;
    logic [POS_W-1:0]           position;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, command, position, value, input ready);
    modport sink   (input valid, command, position, value, output ready);
endinterface

interface ils_rsp_if import ils_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [1:0]                 status;
    logic signed [VALUE_W-1:0]  head_value;
    logic                       head_valid;
    logic [CNT_W-1:0]           element_count;

    modport source (output valid, status, head_value, head_valid, element_count, input ready);
    modport sink   (input valid, status, head_value, head_valid, element_count, output ready);
endinterface

>>> sv/indexed_list_stack_top.sv
// indexed list stack: ordered store with stack view over a row of shifting cells
// a command passes a pending register, then the output register, before its response is valid
// throughput: one command per cycle unless a stalled response holds both registers full
// each insert or delete shifts the whole row at once; the response head reads it afterwards
// reset clears the count, the direction bit and the handshake state; cell data is left as is
module indexed_list_stack_top
    import ils_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_W_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    ils_cmd_if.sink      cmd,
    ils_rsp_if.source    rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = (CW > POS_W) ? CW : POS_W;
    localparam logic [MW-1:0] DEPTH_M = MW'(DEPTH);

    logic [CW-1:0]   count_reg, count_next;
    logic            rev_reg, rev_next;
    logic            pend_valid_reg;
    status_t         pend_status_reg, status_next;
    logic            out_valid_reg;
    status_t         out_status_reg;
    logic [VALUE_W-1:0] out_head_reg;
    logic            out_hvalid_reg;
    logic [CNT_W-1:0] out_count_reg;

    logic            can_load;
    logic            cmd_xfer;
    cell_op_t        op_next;
    logic [MW-1:0]   q_m;
    logic [MW-1:0]   pos_m;
    logic [MW-1:0]   cnt_m;
    logic [MW-1:0]   head_idx_m;
    cell_ctrl_t      ctrl;

    logic [DATA_WIDTH-1:0] din;
    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [DATA_WIDTH-1:0] head_part [DEPTH];
    logic [DATA_WIDTH-1:0] head_data;
    logic [VALUE_W+DATA_WIDTH-1:0] din_ext;
    logic [VALUE_W+DATA_WIDTH-1:0] head_ext;
    logic [MW+CNT_W-1:0]   cnt_ext;

    assign can_load  = !out_valid_reg || rsp.ready;
    assign cmd.ready = !pend_valid_reg || can_load;
    assign cmd_xfer  = cmd.valid && cmd.ready;

    assign pos_m = MW'(cmd.position);
    assign cnt_m = MW'(count_reg);

    // command decode against the current count and direction
    always_comb
    begin
        op_next     = CELL_HOLD;
        q_m         = '0;
        status_next = ST_OK;
        count_next  = count_reg;
        rev_next    = rev_reg;
        unique case (cmd_t'(cmd.command))
            CMD_INSERT:
            begin
                if (pos_m > cnt_m)
                    status_next = ST_RANGE;
                else if (cnt_m == DEPTH_M)
                    status_next = ST_FULL;
                else
                begin
                    op_next    = CELL_INS;
                    q_m        = rev_reg ? (cnt_m - pos_m) : pos_m;
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_DELETE:
            begin
                if (count_reg == '0)
                    status_next = ST_EMPTY;
                else if (pos_m >= cnt_m)
                    status_next = ST_RANGE;
                else
                begin
                    op_next    = CELL_DEL;
                    q_m        = rev_reg ? (cnt_m - MW'(1) - pos_m) : pos_m;
                    count_next = count_reg - CW'(1);
                end
            end
            CMD_REVERSE:
            begin
                if (count_reg == '0)
                    status_next = ST_EMPTY;
                else
                    rev_next = !rev_reg;
            end
            CMD_PEEK:
            begin
                status_next = (count_reg == '0) ? ST_EMPTY : ST_OK;
            end
        endcase
    end

    // logical head is physical 0, or the tail cell when reversed
    assign head_idx_m = rev_reg ? (cnt_m - MW'(1)) : '0;

    assign ctrl.op       = cmd_xfer ? op_next : CELL_HOLD;
    assign ctrl.q        = IDX_MAX_W'(q_m);
    assign ctrl.head_en  = (count_reg != '0);
    assign ctrl.head_idx = IDX_MAX_W'(head_idx_m);

    assign din_ext = {{DATA_WIDTH{1'b0}}, cmd.value};
    assign din     = din_ext[DATA_WIDTH-1:0];

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] left_d;
            logic [DATA_WIDTH-1:0] right_d;
            if (k == 0)
            begin : g_first
                assign left_d = '0;
            end
            else
            begin : g_left
                assign left_d = cell_data[k-1];
            end
            if (k == DEPTH - 1)
            begin : g_last
                assign right_d = '0;
            end
            else
            begin : g_right
                assign right_d = cell_data[k+1];
            end
            ils_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .INDEX      (k)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .din        (din),
                .left_data  (left_d),
                .right_data (right_d),
                .data       (cell_data[k]),
                .head_part  (head_part[k])
            );
        end
    endgenerate

    always_comb
    begin
        head_data = '0;
        for (int i = 0; i < DEPTH; i++)
            head_data = head_data | head_part[i];
    end

    assign head_ext = {{VALUE_W{1'b0}}, head_data};
    assign cnt_ext  = {{CNT_W{1'b0}}, cnt_m};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            rev_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd_xfer)
            begin
                count_reg <= count_next;
                rev_reg   <= rev_next;
            end
            if (cmd_xfer)
                pend_valid_reg <= 1'b1;
            else if (can_load)
                pend_valid_reg <= 1'b0;
            if (can_load)
                out_valid_reg <= pend_valid_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_xfer)
            pend_status_reg <= status_next;
        if (can_load && pend_valid_reg)
        begin
            out_status_reg <= pend_status_reg;
            out_head_reg   <= head_ext[VALUE_W-1:0];
            out_hvalid_reg <= (count_reg != '0);
            out_count_reg  <= cnt_ext[CNT_W-1:0];
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.head_value    = out_head_reg;
    assign rsp.head_valid    = out_hvalid_reg;
    assign rsp.element_count = out_count_reg;

endmodule

>>> sv/ils_cell.sv
// one storage cell of the shifting element row
// depends on ils_pkg; instantiated DEPTH times by indexed_list_stack_top
module ils_cell
    import ils_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_W_DEF,
    parameter int INDEX      = 0
)
(
    input  logic                  clk,
    input  cell_ctrl_t            ctrl,
    input  logic [DATA_WIDTH-1:0] din,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    output logic [DATA_WIDTH-1:0] data,
    output logic [DATA_WIDTH-1:0] head_part
);

    localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(INDEX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            CELL_INS:
            begin
                // cells above the insert point take from the lower neighbor
                if (MY_IDX > ctrl.q)
                    data_next = left_data;
                else if (MY_IDX == ctrl.q)
                    data_next = din;
            end
            CELL_DEL:
            begin
                if (MY_IDX >= ctrl.q)
                    data_next = right_data;
            end
            default: data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data      = data_reg;
    assign head_part = (ctrl.head_en && ctrl.head_idx == MY_IDX) ? data_reg : '0;

endmodule

>>> sv/ils_checker.sv
// port-level checks for the indexed list stack, bound to the top level
// depends on ils_pkg and indexed_list_stack_top
module ils_checker
    import ils_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 rsp_valid,
    input logic                 rsp_ready,
    input logic [1:0]           status,
    input logic [VALUE_W-1:0]   head_value,
    input logic                 head_valid,
    input logic [CNT_W-1:0]     element_count
);

    // a stalled response holds its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(head_value)
            && $stable(head_valid) && $stable(element_count))
        else $error("response changed while stalled");

    // head flag follows the count, empty head reads zero
    a_head_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (head_valid == (element_count != '0)) && (head_valid || head_value == '0))
        else $error("head flag or value inconsistent with count");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_EMPTY |-> element_count == '0 && !head_valid)
        else $error("empty status with stored elements");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_FULL |-> element_count == CNT_W'(DEPTH))
        else $error("full status below capacity");

endmodule

bind indexed_list_stack_top ils_checker #(
    .DEPTH (DEPTH)
) u_ils_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .status        (rsp.status),
    .head_value    (rsp.head_value),
    .head_valid    (rsp.head_valid),
    .element_count (rsp.element_count)
);

>>> tb/sv/indexed_list_stack_top_tb.sv
// self-checking testbench for indexed_list_stack_top: random and directed commands, scoreboarded responses
// depends on ils_pkg, ils_if (ils_cmd_if, ils_rsp_if) and the indexed_list_stack_top rtl
module indexed_list_stack_top_tb;
    import ils_pkg::*;

    localparam int DEPTH      = DEPTH_DEF;
    localparam int DATA_W     = DATA_W_DEF;
    localparam int NUM_RANDOM = 1150;

    typedef struct {
        cmd_t                command;
        logic [POS_W-1:0]    position;
        logic [VALUE_W-1:0]  value;
    } stack_cmd_t;

    typedef struct {
        status_t             status;
        logic [VALUE_W-1:0]  head_value;
        logic                head_valid;
        logic [CNT_W-1:0]    element_count;
    } stack_resp_t;

    logic clk;
    logic rst_n;

    ils_cmd_if cmd_ch ();
    ils_rsp_if rsp_ch ();

    indexed_list_stack_top #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_W)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    stack_cmd_t  pending_cmds [$];
    stack_resp_t expected_resps [$];

    // shadow of the store used for prediction
    logic [DATA_W-1:0] shadow_cells [DEPTH];
    int unsigned       shadow_count;
    bit                shadow_reversed;

    int unsigned gen_count;
    int unsigned cmds_taken;
    int unsigned err_count;

    int burst_left;
    int gap_left;
    int rx_mode;
    int rx_left;
    int rx_tick;
    int hold_cycles;
    int unsigned next_hold_at;
    logic hold_off;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // applies one command to the shadow store and returns the response it should give
    function automatic stack_resp_t apply_command(stack_cmd_t c);
        stack_resp_t r;
        int unsigned p;
        int unsigned q;
        int unsigned k;
        p = c.position;
        r.status = ST_OK;
        case (c.command)
            CMD_INSERT:
            begin
                if (p > shadow_count)
                    r.status = ST_RANGE;
                else if (shadow_count >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    q = shadow_reversed ? shadow_count - p : p;
                    for (k = shadow_count; k > q; k--)
                        shadow_cells[k] = shadow_cells[k-1];
                    shadow_cells[q] = c.value[DATA_W-1:0];
                    shadow_count++;
                end
            end
            CMD_DELETE:
            begin
                if (shadow_count == 0)
                    r.status = ST_EMPTY;
                else if (p >= shadow_count)
                    r.status = ST_RANGE;
                else
                begin
                    q = shadow_reversed ? shadow_count - 1 - p : p;
                    for (k = q; k + 1 < shadow_count; k++)
                        shadow_cells[k] = shadow_cells[k+1];
                    shadow_count--;
                end
            end
            CMD_REVERSE:
            begin
                if (shadow_count == 0)
                    r.status = ST_EMPTY;
                else
                    shadow_reversed = !shadow_reversed;
            end
            default:
            begin
                if (shadow_count == 0)
                    r.status = ST_EMPTY;
            end
        endcase
        r.head_value = '0;
        if (shadow_count > 0)
            r.head_value = VALUE_W'(shadow_cells[shadow_reversed ? shadow_count - 1 : 0]);
        r.head_valid    = (shadow_count > 0);
        r.element_count = CNT_W'(shadow_count);
        return r;
    endfunction

    // queues a command and tracks the count it leaves behind
    task automatic queue_cmd(cmd_t c, int unsigned pos, logic [VALUE_W-1:0] v);
        stack_cmd_t item;
        item.command  = c;
        item.position = POS_W'(pos);
        item.value    = v;
        pending_cmds.push_back(item);
        if (c == CMD_INSERT && pos <= gen_count && gen_count < DEPTH)
            gen_count++;
        else if (c == CMD_DELETE && pos < gen_count)
            gen_count--;
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 19))
            0:       v = '0;
            1:       v = {1'b0, {(VALUE_W-1){1'b1}}};
            2:       v = {1'b1, {(VALUE_W-1){1'b0}}};
            3:       v = '1;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // mostly legal positions, biased toward head and tail, with some noise
    function automatic int unsigned pick_position(cmd_t c, int unsigned cnt);
        int unsigned top;
        int sel;
        sel = $urandom_range(0, 99);
        if (c == CMD_REVERSE || c == CMD_PEEK || sel < 12)
            return $urandom_range(0, 31);
        if (c == CMD_DELETE && cnt == 0)
            return 0;
        top = (c == CMD_INSERT) ? cnt : cnt - 1;
        if (sel < 50)
            return 0;
        else if (sel < 70)
            return top;
        return $urandom_range(0, top);
    endfunction

    // driver: bursts of transfers separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        stack_cmd_t item;
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
        end
        else if (!cmd_ch.valid || cmd_ch.ready)
        begin
            if (gap_left > 0)
            begin
                cmd_ch.valid <= 1'b0;
                gap_left--;
            end
            else if (pending_cmds.size() > 0)
            begin
                item = pending_cmds.pop_front();
                cmd_ch.valid    <= 1'b1;
                cmd_ch.command  <= item.command;
                cmd_ch.position <= item.position;
                cmd_ch.value    <= item.value;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left--;
            end
            else
                cmd_ch.valid <= 1'b0;
        end
    end

    // receiver: ready pattern switches between modes, forced low during a hold-off
    always @(posedge clk or negedge rst_n)
    begin
        logic rdy;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rx_left <= 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(20, 150);
            end
            rx_left--;
            rx_tick++;
            case (rx_mode)
                0:       rdy = 1'b1;
                1:       rdy = $urandom_range(0, 1);
                2:       rdy = (rx_tick % 4 == 0);
                default: rdy = ($urandom_range(0, 4) != 0);
            endcase
            rsp_ch.ready <= rdy && !hold_off;
        end
    end

    // long receiver hold-off so the block fills and backs up its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_off <= 1'b0;
        end
        else if (hold_off)
        begin
            hold_cycles++;
            if (hold_cycles >= 150)
                hold_off <= 1'b0;
        end
        else if (cmds_taken >= next_hold_at)
        begin
            hold_off     <= 1'b1;
            hold_cycles  = 0;
            next_hold_at = next_hold_at + 500;
        end
    end

    // monitor: predict on each command transfer, check on each response transfer
    always @(posedge clk)
    begin
        stack_cmd_t  c;
        stack_resp_t exp_r;
        if (rst_n && cmd_ch.valid && cmd_ch.ready)
        begin
            c.command  = cmd_t'(cmd_ch.command);
            c.position = cmd_ch.position;
            c.value    = cmd_ch.value;
            expected_resps.push_back(apply_command(c));
            cmds_taken++;
        end
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_resps.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected response: status=%0d head=%h valid=%b count=%0d",
                             rsp_ch.status, rsp_ch.head_value, rsp_ch.head_valid,
                             rsp_ch.element_count);
            end
            else
            begin
                exp_r = expected_resps.pop_front();
                if (rsp_ch.status !== exp_r.status || rsp_ch.head_value !== exp_r.head_value
                    || rsp_ch.head_valid !== exp_r.head_valid
                    || rsp_ch.element_count !== exp_r.element_count)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("mismatch: exp status=%0d head=%h valid=%b count=%0d / act status=%0d head=%h valid=%b count=%0d",
                                 exp_r.status, exp_r.head_value, exp_r.head_valid,
                                 exp_r.element_count, rsp_ch.status, rsp_ch.head_value,
                                 rsp_ch.head_valid, rsp_ch.element_count);
                end
            end
        end
    end

    initial
    begin
        int unsigned generated;
        int phase;
        int phase_len;
        int sel;
        cmd_t c;
        clk             = 1'b0;
        rst_n           = 1'b0;
        cmd_ch.valid    = 1'b0;
        cmd_ch.command  = CMD_PEEK;
        cmd_ch.position = '0;
        cmd_ch.value    = '0;
        rsp_ch.ready    = 1'b0;
        hold_off        = 1'b0;
        shadow_count    = 0;
        shadow_reversed = 1'b0;
        gen_count       = 0;
        cmds_taken      = 0;
        err_count       = 0;
        burst_left      = 1;
        gap_left        = 0;
        rx_mode         = 0;
        rx_left         = 0;
        rx_tick         = 0;
        hold_cycles     = 0;
        next_hold_at    = 300;

        // empty store cases and insert past the count on empty
        queue_cmd(CMD_PEEK, 0, '0);
        queue_cmd(CMD_DELETE, 0, '1);
        queue_cmd(CMD_REVERSE, 31, '0);
        queue_cmd(CMD_INSERT, 1, 32'h1234_5678);
        // fill to full with pushes, appends and middle inserts
        for (int i = 0; i < DEPTH; i++)
        begin
            if (i % 3 == 0)
                queue_cmd(CMD_INSERT, 0, pick_value());
            else if (i % 3 == 1)
                queue_cmd(CMD_INSERT, gen_count, pick_value());
            else
                queue_cmd(CMD_INSERT, gen_count / 2, pick_value());
        end
        queue_cmd(CMD_INSERT, 0, '1);
        queue_cmd(CMD_INSERT, DEPTH + 1, '0);
        queue_cmd(CMD_INSERT, 31, '0);
        queue_cmd(CMD_DELETE, DEPTH, '0);
        queue_cmd(CMD_DELETE, 31, '0);
        queue_cmd(CMD_REVERSE, 0, '0);
        queue_cmd(CMD_PEEK, 31, '1);
        queue_cmd(CMD_DELETE, 0, '0);
        queue_cmd(CMD_DELETE, gen_count - 1, '0);

        // random phases: fill-heavy, drain-heavy and mixed
        generated = 0;
        while (generated < NUM_RANDOM)
        begin
            phase     = $urandom_range(0, 2);
            phase_len = $urandom_range(20, 80);
            for (int j = 0; j < phase_len; j++)
            begin
                sel = $urandom_range(0, 99);
                if (phase == 0)
                    c = (sel < 70) ? CMD_INSERT : (sel < 85) ? CMD_DELETE
                        : (sel < 93) ? CMD_REVERSE : CMD_PEEK;
                else if (phase == 1)
                    c = (sel < 15) ? CMD_INSERT : (sel < 85) ? CMD_DELETE
                        : (sel < 93) ? CMD_REVERSE : CMD_PEEK;
                else
                    c = cmd_t'(sel % 4);
                queue_cmd(c, pick_position(c, gen_count), pick_value());
                generated++;
            end
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_cmds.size() != 0 || cmd_ch.valid)
            @(negedge clk);
        while (expected_resps.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (expected_resps.size() != 0)
            err_count++;
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> files.f
sv/ils_pkg.sv
sv/ils_if.sv
sv/ils_cell.sv
sv/indexed_list_stack_top.sv
sv/ils_checker.sv
tb/sv/indexed_list_stack_top_tb.sv
